@@ hw/rtl/lobm_pkg.sv @@
// lobm_pkg: shared types and codes of the limit order book matcher
// no dependencies
package lobm_pkg;

  localparam int unsigned DefPriceLevels = 256;
  localparam int unsigned DefOrderSlots  = 32;
  localparam int unsigned MaxCompletions = 32;
  localparam int unsigned TickW = 8;
  localparam int unsigned QtyW  = 32;
  localparam int unsigned IdW   = 32;

  typedef enum logic [1:0] {
    ACT_ADD_BUY  = 2'd0,
    ACT_ADD_SELL = 2'd1,
    ACT_MATCH    = 2'd2,
    ACT_NONE     = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_ACCEPTED  = 3'd0,
    KIND_REJ_ZERO  = 3'd1,
    KIND_REJ_FULL  = 3'd2,
    KIND_COMPLETED = 3'd3,
    KIND_MATCH_END = 3'd4
  } kind_e;

  // one resting order
  typedef struct packed {
    logic             valid;
    logic [IdW-1:0]   id;
    logic [QtyW-1:0]  rem;
    logic [TickW-1:0] tick;
  } order_t;

  // per-side control of the order chain
  typedef struct packed {
    logic            ins;
    logic            pop;
    logic            upd;
    logic [QtyW-1:0] upd_rem;
  } side_ctrl_t;

endpackage

@@ hw/rtl/lobm_if.sv @@
// lobm_in_if and lobm_out_if: valid/ready channels of the matcher
// depends on lobm_pkg
interface lobm_in_if import lobm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [TickW-1:0] price_tick;
  logic [QtyW-1:0]  quantity;
  logic [IdW-1:0]   order_tag;
  modport source (output valid, action, price_tick, quantity, order_tag, input ready);
  modport sink (input valid, action, price_tick, quantity, order_tag, output ready);
  modport monitor (input valid, ready, action, price_tick, quantity, order_tag);
endinterface

interface lobm_out_if import lobm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       kind;
  logic [IdW-1:0]   order_id_res;
  logic             side;
  logic [TickW-1:0] price_tick_res;
  logic             last;
  modport source (output valid, kind, order_id_res, side, price_tick_res, last, input ready);
  modport sink (input valid, kind, order_id_res, side, price_tick_res, last, output ready);
  modport monitor (input valid, ready, kind, order_id_res, side, price_tick_res, last);
endinterface

@@ hw/rtl/lobm_cell.sv @@
// lobm_cell: one place in a priority-sorted order chain
// depends on lobm_pkg
module lobm_cell import lobm_pkg::*; #(
  parameter bit IsSell = 1'b0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  side_ctrl_t ctrl_i,
  input  logic       head_i,
  input  order_t     new_i,
  input  order_t     left_i,
  input  logic       left_before_i,
  input  order_t     right_i,
  output order_t     q_o,
  output logic       before_o
);

  order_t q_q, q_d;

  // resting order keeps priority over a new one at the same tick
  assign before_o = q_q.valid &&
                    (IsSell ? (q_q.tick <= new_i.tick) : (q_q.tick >= new_i.tick));

  always_comb begin
    q_d = q_q;
    if (ctrl_i.pop) begin
      q_d = right_i;
    end else if (ctrl_i.ins) begin
      if (!before_o) begin
        q_d = left_before_i ? new_i : left_i;
      end
    end else if (ctrl_i.upd && head_i) begin
      q_d.rem = ctrl_i.upd_rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

@@ hw/rtl/lobm_side.sv @@
// lobm_side: chain of cells holding one side of the book, best order at the head
// depends on lobm_pkg and lobm_cell
module lobm_side import lobm_pkg::*; #(
  parameter int unsigned OrderSlots = DefOrderSlots,
  parameter bit          IsSell     = 1'b0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  side_ctrl_t ctrl_i,
  input  order_t     new_i,
  output order_t     head_o
);

  order_t cell_q [OrderSlots];
  logic   ahead  [OrderSlots];

  for (genvar i = 0; i < OrderSlots; i++) begin : g_cell
    order_t left, right;
    logic   left_before;
    if (i == 0) begin : g_first
      assign left        = '0;
      assign left_before = 1'b1;
    end else begin : g_mid
      assign left        = cell_q[i-1];
      assign left_before = ahead[i-1];
    end
    if (i == OrderSlots - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cell_q[i+1];
    end
    lobm_cell #(.IsSell(IsSell)) u_cell (
      .clk_i,
      .rst_ni,
      .ctrl_i,
      .head_i       (i == 0),
      .new_i,
      .left_i       (left),
      .left_before_i(left_before),
      .right_i      (right),
      .q_o          (cell_q[i]),
      .before_o     (ahead[i])
    );
  end

  assign head_o = cell_q[0];

endmodule

@@ hw/rtl/limit_order_book_matcher.sv @@
// limit_order_book_matcher: top level of the single-symbol order book
// depends on lobm_pkg, lobm_if, lobm_side
//
// Each side of the book is a chain of ORDER_SLOTS cells kept sorted by price-time
// priority, so the best order always sits in the head cell; an insert or a removal
// shifts the chain by one place. An add transaction yields a single result that
// sits in the output register from the cycle after it is accepted. A match
// transaction yields one completion result per finished order and then a closing
// match-done result; when the completion budget runs out between a buy and a sell
// that both finish, the sell is not reported. Each pairing is one 32-bit compare
// and subtract on the two head cells. A result that the receiver holds off stalls
// the sequence. Results are held in an output register; the block takes no new
// input transaction until the previous one has produced all its results and the
// output register is free.
module limit_order_book_matcher import lobm_pkg::*; #(
  parameter int unsigned PRICE_LEVELS = DefPriceLevels,
  parameter int unsigned ORDER_SLOTS  = DefOrderSlots
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  lobm_in_if.sink   in_i,
  lobm_out_if.source out_o
);

  localparam int unsigned CntW    = $clog2(ORDER_SLOTS + 1);
  localparam int unsigned NW      = $clog2(MaxCompletions + 1);
  localparam int unsigned MaxTick = (PRICE_LEVELS < 256) ? PRICE_LEVELS - 1 : 255;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STEP = 2'd1;
  localparam logic [1:0] ST_SELL = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [NW-1:0]   n_q, n_d;

  logic             ov_q, ov_d;
  logic [2:0]       okind_q, okind_d;
  logic [IdW-1:0]   oid_q, oid_d;
  logic             oside_q, oside_d;
  logic [TickW-1:0] otick_q, otick_d;
  logic             olast_q, olast_d;

  side_ctrl_t bctrl, sctrl;
  order_t     new_ord, bhead, shead;
  logic       out_free, in_fire;
  logic [TickW-1:0] tick_sat;
  logic [QtyW-1:0]  m, brem, srem;

  assign out_free = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_fire = in_i.valid && in_i.ready;

  assign tick_sat = (in_i.price_tick > TickW'(MaxTick)) ? TickW'(MaxTick) : in_i.price_tick;
  assign new_ord  = '{valid: 1'b1, id: in_i.order_tag, rem: in_i.quantity, tick: tick_sat};

  // pairing arithmetic on the two head orders
  assign m    = (bhead.rem < shead.rem) ? bhead.rem : shead.rem;
  assign brem = bhead.rem - m;
  assign srem = shead.rem - m;

  lobm_side #(.OrderSlots(ORDER_SLOTS), .IsSell(1'b0)) u_buy (
    .clk_i, .rst_ni, .ctrl_i(bctrl), .new_i(new_ord), .head_o(bhead)
  );
  lobm_side #(.OrderSlots(ORDER_SLOTS), .IsSell(1'b1)) u_sell (
    .clk_i, .rst_ni, .ctrl_i(sctrl), .new_i(new_ord), .head_o(shead)
  );

  // sequencer for adds and matching
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    n_d     = n_q;
    bctrl   = '0;
    sctrl   = '0;
    ov_d    = ov_q && !out_o.ready;
    okind_d = okind_q;
    oid_d   = oid_q;
    oside_d = oside_q;
    otick_d = otick_q;
    olast_d = olast_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_i.action)
            ACT_ADD_BUY, ACT_ADD_SELL: begin
              ov_d    = 1'b1;
              oid_d   = in_i.order_tag;
              oside_d = in_i.action[0];
              otick_d = tick_sat;
              olast_d = 1'b1;
              if (in_i.quantity == '0) begin
                okind_d = KIND_REJ_ZERO;
              end else if (count_q == CntW'(ORDER_SLOTS)) begin
                okind_d = KIND_REJ_FULL;
              end else begin
                okind_d = KIND_ACCEPTED;
                count_d = count_q + 1'b1;
                if (in_i.action[0]) begin
                  sctrl.ins = 1'b1;
                end else begin
                  bctrl.ins = 1'b1;
                end
              end
            end
            ACT_MATCH: begin
              n_d     = '0;
              state_d = ST_STEP;
            end
            default: ;
          endcase
        end
      end
      ST_STEP: begin
        if (out_free) begin
          ov_d = 1'b1;
          if (n_q == NW'(MaxCompletions) || !bhead.valid || !shead.valid ||
              shead.tick > bhead.tick) begin
            okind_d = KIND_MATCH_END;
            oid_d   = '0;
            oside_d = 1'b0;
            otick_d = '0;
            olast_d = 1'b1;
            state_d = ST_IDLE;
          end else begin
            okind_d = KIND_COMPLETED;
            olast_d = 1'b0;
            n_d     = n_q + 1'b1;
            count_d = count_q - 1'b1;
            if (brem == '0) begin
              bctrl.pop     = 1'b1;
              sctrl.upd     = 1'b1;
              sctrl.upd_rem = srem;
              oid_d   = bhead.id;
              oside_d = 1'b0;
              otick_d = bhead.tick;
              if (srem == '0) begin
                state_d = ST_SELL;
              end
            end else begin
              bctrl.upd     = 1'b1;
              bctrl.upd_rem = brem;
              sctrl.pop     = 1'b1;
              oid_d   = shead.id;
              oside_d = 1'b1;
              otick_d = shead.tick;
            end
          end
        end
      end
      ST_SELL: begin
        // sell head also finished; report it if the budget allows
        if (n_q == NW'(MaxCompletions)) begin
          state_d = ST_STEP;
        end else if (out_free) begin
          ov_d      = 1'b1;
          okind_d   = KIND_COMPLETED;
          olast_d   = 1'b0;
          oid_d     = shead.id;
          oside_d   = 1'b1;
          otick_d   = shead.tick;
          sctrl.pop = 1'b1;
          n_d       = n_q + 1'b1;
          count_d   = count_q - 1'b1;
          state_d   = ST_STEP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      n_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      n_q     <= n_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okind_q <= okind_d;
    oid_q   <= oid_d;
    oside_q <= oside_d;
    otick_q <= otick_d;
    olast_q <= olast_d;
  end

  assign out_o.valid          = ov_q;
  assign out_o.kind           = okind_q;
  assign out_o.order_id_res   = oid_q;
  assign out_o.side           = oside_q;
  assign out_o.price_tick_res = otick_q;
  assign out_o.last           = olast_q;

endmodule

@@ hw/rtl/lobm_checker.sv @@
// lobm_checker: port-level assertions on the order book matcher, bound to the top
// depends on lobm_pkg
module lobm_checker import lobm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_action_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_kind_i,
  input logic       out_last_i
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i))
    else $error("result dropped while stalled");

  // an add transaction yields exactly one final result in the next cycle
  a_add_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i == ACT_ADD_BUY || in_action_i == ACT_ADD_SELL)
    |=> out_valid_i && out_last_i &&
        (out_kind_i == KIND_ACCEPTED || out_kind_i == KIND_REJ_ZERO ||
         out_kind_i == KIND_REJ_FULL))
    else $error("add without result");

  // completions are never final, match end always is
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (out_kind_i != KIND_COMPLETED)))
    else $error("last flag does not fit kind");

  // no new input while a result is stuck
  a_no_accept_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i || out_ready_i)
    else $error("input taken while output stalled");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_action_i(in_i.action),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_kind_i (out_o.kind),
  .out_last_i (out_o.last)
);

@@ tb/sv/tb_limit_order_book_matcher.sv @@
// tb_limit_order_book_matcher: self-checking testbench of the order book matcher
// depends on lobm_pkg, lobm_if and limit_order_book_matcher; predicts every result
// from its own book of resting orders and checks each output transaction in order
module tb_limit_order_book_matcher;
  import lobm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 60;

  // one resting order as the predictor keeps it
  typedef struct {
    logic [IdW-1:0]   id;
    logic [QtyW-1:0]  rem;
    logic [TickW-1:0] tick;
  } resting_t;

  typedef struct {
    kind_e            kind;
    logic [IdW-1:0]   id;
    logic             side;
    logic [TickW-1:0] tick;
    logic             last;
  } report_t;

  logic clk;
  logic rst_n;
  lobm_in_if  in_if();
  lobm_out_if out_if();

  limit_order_book_matcher dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  resting_t bids[$];
  resting_t asks[$];
  report_t  pending_reports[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit calm;
  int unsigned rx_hold;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[limit_order_book_matcher] ERROR");
      $finish;
    end
  end

  // receiver readiness: long hold-off, calm stretch or random stalls
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_if.ready = 1'b0;
        rx_hold--;
      end else if (calm) begin
        out_if.ready = 1'b1;
      end else begin
        out_if.ready = ($urandom_range(99) >= 32);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    report_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d id=%h", out_if.kind, out_if.order_id_res);
      end else begin
        exp_r = pending_reports[0];
        pending_reports.delete(0);
        if (out_if.kind !== exp_r.kind || out_if.order_id_res !== exp_r.id ||
            out_if.side !== exp_r.side || out_if.price_tick_res !== exp_r.tick ||
            out_if.last !== exp_r.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch exp kind=%0d id=%h side=%0d tick=%0d last=%0d",
                      " / got %0d %h %0d %0d %0d"},
                     exp_r.kind, exp_r.id, exp_r.side, exp_r.tick, exp_r.last,
                     out_if.kind, out_if.order_id_res, out_if.side,
                     out_if.price_tick_res, out_if.last);
        end
      end
    end
  end

  function automatic void post_report(kind_e k, logic [IdW-1:0] id, logic sd,
                                      logic [TickW-1:0] tk, logic lst);
    report_t r;
    r.kind = k;
    r.id = id;
    r.side = sd;
    r.tick = tk;
    r.last = lst;
    pending_reports.insert(pending_reports.size(), r);
  endfunction

  // queues are in arrival order, so the first strict best is the oldest
  function automatic int top_bid_idx();
    int b;
    b = -1;
    foreach (bids[i])
      if (b < 0 || bids[i].tick > bids[b].tick) b = i;
    return b;
  endfunction

  function automatic int top_ask_idx();
    int a;
    a = -1;
    foreach (asks[i])
      if (a < 0 || asks[i].tick < asks[a].tick) a = i;
    return a;
  endfunction

  // book predictor: applies one accepted transaction and queues its results
  function automatic void predict_book(action_e act, logic [TickW-1:0] tk,
                                       logic [QtyW-1:0] qty, logic [IdW-1:0] id);
    resting_t o;
    int n;
    int b;
    int a;
    logic [QtyW-1:0] m;
    logic bdone;
    logic adone;
    case (act)
      ACT_ADD_BUY, ACT_ADD_SELL: begin
        if (qty == 0) begin
          post_report(KIND_REJ_ZERO, id, act == ACT_ADD_SELL, tk, 1'b1);
        end else if (bids.size() + asks.size() >= DefOrderSlots) begin
          post_report(KIND_REJ_FULL, id, act == ACT_ADD_SELL, tk, 1'b1);
        end else begin
          o.id = id;
          o.rem = qty;
          o.tick = tk;
          if (act == ACT_ADD_BUY) bids.insert(bids.size(), o);
          else asks.insert(asks.size(), o);
          post_report(KIND_ACCEPTED, id, act == ACT_ADD_SELL, tk, 1'b1);
        end
      end
      ACT_MATCH: begin
        n = 0;
        while (n < MaxCompletions) begin
          b = top_bid_idx();
          a = top_ask_idx();
          if (b < 0 || a < 0 || asks[a].tick > bids[b].tick) break;
          m = (bids[b].rem < asks[a].rem) ? bids[b].rem : asks[a].rem;
          bids[b].rem -= m;
          asks[a].rem -= m;
          bdone = (bids[b].rem == 0);
          adone = (asks[a].rem == 0);
          if (bdone) begin
            post_report(KIND_COMPLETED, bids[b].id, 1'b0, bids[b].tick, 1'b0);
            bids.delete(b);
            n++;
          end
          if (adone) begin
            if (n >= MaxCompletions) break;
            post_report(KIND_COMPLETED, asks[a].id, 1'b1, asks[a].tick, 1'b0);
            asks.delete(a);
            n++;
          end
        end
        post_report(KIND_MATCH_END, '0, 1'b0, '0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // send one transaction and predict it on acceptance
  task automatic send_item(action_e act, logic [TickW-1:0] tk,
                           logic [QtyW-1:0] qty, logic [IdW-1:0] id);
    @(negedge clk);
    if (!calm && $urandom_range(99) < 32) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.action = act;
    in_if.price_tick = tk;
    in_if.quantity = qty;
    in_if.order_tag = id;
    forever begin
      @(posedge clk);
      if (in_if.ready) break;
    end
    predict_book(act, tk, qty, id);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // rejects, unused action and an empty-book match with junk fields
  task automatic test_rejects();
    send_item(ACT_ADD_BUY, 8'd7, '0, 32'h0000_0001);
    send_item(ACT_ADD_SELL, 8'd200, '0, 32'hFFFF_FFFF);
    send_item(ACT_NONE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_MATCH, 8'hAA, 32'h5555_5555, 32'hDEAD_BEEF);
  endtask

  // field extremes crossing at opposite ends of the tick range
  task automatic test_extremes();
    send_item(ACT_ADD_BUY, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_ADD_SELL, 8'h00, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(ACT_ADD_SELL, 8'hFF, 32'h0000_0001, 32'h8000_0000);
    send_item(ACT_MATCH, '0, '0, '0);
    send_item(ACT_ADD_BUY, 8'h00, 32'h0000_0001, 32'h7FFF_FFFF);
    send_item(ACT_MATCH, '0, '0, '0);
    send_item(ACT_ADD_BUY, 8'hFF, 32'h0000_0002, 32'h1234_5678);
    send_item(ACT_MATCH, '0, '0, '0);
    wait_drained();
  endtask

  // full pool, a rejected add, then a match that uses the whole completion budget
  task automatic test_full_pool();
    for (int i = 0; i < 16; i++) send_item(ACT_ADD_BUY, 8'd50, 32'd1, 32'h100 + i);
    for (int i = 0; i < 16; i++) send_item(ACT_ADD_SELL, 8'd50, 32'd1, 32'h200 + i);
    send_item(ACT_ADD_BUY, 8'd60, 32'd5, 32'h300);
    send_item(ACT_MATCH, '0, '0, '0);
    send_item(ACT_MATCH, '0, '0, '0);
    wait_drained();
  endtask

  task automatic send_random_item();
    int unsigned pick;
    action_e act;
    logic [TickW-1:0] tk;
    logic [QtyW-1:0] qty;
    pick = $urandom_range(99);
    act = (pick < 42) ? ACT_ADD_BUY : (pick < 84) ? ACT_ADD_SELL :
          (pick < 97) ? ACT_MATCH : ACT_NONE;
    tk = ($urandom_range(9) == 0) ? TickW'($urandom_range(255)) :
                                    TickW'($urandom_range(132, 124));
    pick = $urandom_range(19);
    qty = (pick == 0) ? '0 : (pick == 1) ? $urandom() : $urandom_range(30, 1);
    send_item(act, tk, qty, $urandom());
  endtask

  // random mix; a calm stretch in the middle, a sender pause at the end
  task automatic test_random();
    for (int i = 0; i < 50; i++) begin
      calm = (i >= 15 && i < 35);
      send_random_item();
    end
    calm = 1'b0;
    send_item(ACT_MATCH, '0, '0, '0);
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    rx_hold = 300;
    for (int i = 0; i < 8; i++) send_random_item();
    send_item(ACT_MATCH, '0, '0, '0);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    calm = 1'b0;
    rx_hold = 0;
    mismatches = 0;
    cycles = 0;
    in_if.valid = 1'b0;
    in_if.action = ACT_NONE;
    in_if.price_tick = '0;
    in_if.quantity = '0;
    in_if.order_tag = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_rejects();
    test_extremes();
    test_full_pool();
    test_random();
    test_backpressure();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("[limit_order_book_matcher] OK");
    end else begin
      $display("[limit_order_book_matcher] ERROR");
    end
    $finish;
  end

endmodule
